// File: rtl/orbit_camera_yaw_pitch_rotate_unit_assert.svh
// Assertion macros shared by the orbit camera RTL.
// OCYP_ASSERT checks a property at every rising clock edge outside reset.
// OCYP_ASSERT_NEXT checks that a condition implies another in the next cycle.
`ifndef ORBIT_CAMERA_YAW_PITCH_ROTATE_UNIT_ASSERT_SVH
`define ORBIT_CAMERA_YAW_PITCH_ROTATE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define OCYP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define OCYP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define OCYP_ASSERT(lbl, clk, rstn, prop, msg)
`define OCYP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: rtl/ocyp_pkg.sv
`timescale 1ns / 1ps
package ocyp_pkg;

  localparam int unsigned SINE_FRAC_BITS_DFLT = 14;
  localparam int unsigned OUT_FRAC_BITS_DFLT  = 6;

  localparam int unsigned PTR_W       = 13;
  localparam int unsigned VEC_W       = 8;
  localparam int unsigned OUT_W       = 15;
  localparam int unsigned ANG_W       = 9;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 96;

  localparam int OUT_MAX = 16383;
  localparam int OUT_MIN = -16384;

  localparam logic [ANG_W-1:0] DEG_ONE      = 9'd1;
  localparam logic [ANG_W-1:0] DEG_QUARTER  = 9'd90;
  localparam logic [ANG_W-1:0] DEG_HALF     = 9'd180;
  localparam logic [ANG_W-1:0] DEG_3QUARTER = 9'd270;
  localparam logic [ANG_W-1:0] DEG_WRAP_LOW = 9'd359;
  localparam logic [ANG_W-1:0] DEG_FULL     = 9'd360;

  localparam int unsigned QUARTER_LEN = 91;

  // Pi in Q30.
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_YAW_LOCK   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PITCH_LOCK = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_EYE_X      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_EYE_Y      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_EYE_Z      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_UP_X       = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_UP_Y       = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_UP_Z       = 3'd7;

  // Control of the accumulate stage of the shared multiplier.
  typedef struct packed {
    logic use_acc;   // add to the running accumulator, else start fresh
    logic add_half;  // when starting fresh, preload the rounding offset
    logic shift_up;  // scale the product by one sine unit first
    logic negate;    // subtract the product
  } mac_op_t;

  // Sine of a whole degree in 0..90, by a Q30 Taylor series, rounded to frac bits.
  // Only evaluated at elaboration to build the constant table.
  function automatic logic [31:0] sin_fixed(input int unsigned deg, input int unsigned frac);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] rnd;
    x    = (64'(deg) * PI_Q30) / 64'd180;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
    term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
    term = ((term * x2) >> 30) / 64'd342; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd420; sum = sum + term;
    rnd  = (sum + (64'd1 << (29 - frac))) >> (30 - frac);
    return rnd[31:0];
  endfunction

endpackage

// File: rtl/ocyp_sincos.sv
`timescale 1ns / 1ps
module ocyp_sincos import ocyp_pkg::*; #(
  parameter int unsigned SINE_FRAC_BITS = SINE_FRAC_BITS_DFLT
) (
  input  logic [ANG_W-1:0]                angle_i,
  output logic signed [SINE_FRAC_BITS+1:0] sin_o,
  output logic signed [SINE_FRAC_BITS+1:0] cos_o
);

  localparam int unsigned MAG_W = SINE_FRAC_BITS + 1;
  localparam int unsigned SIN_W = SINE_FRAC_BITS + 2;
  localparam int unsigned IDX_W = $clog2(QUARTER_LEN);

  // Quarter-wave table; every entry is fixed at elaboration.
  logic [MAG_W-1:0] sin_tab [QUARTER_LEN];

  for (genvar d = 0; d < QUARTER_LEN; d++) begin : g_tab
    assign sin_tab[d] = MAG_W'(sin_fixed(d, SINE_FRAC_BITS));
  end

  // Folds a degree in 0..359 onto the first quadrant: {negate, table index}.
  function automatic logic [IDX_W:0] fold(input logic [ANG_W-1:0] deg);
    logic [ANG_W-1:0] idx;
    logic             neg;
    priority if (deg <= DEG_QUARTER) begin
      idx = deg;
      neg = 1'b0;
    end else if (deg <= DEG_HALF) begin
      idx = DEG_HALF - deg;
      neg = 1'b0;
    end else if (deg <= DEG_3QUARTER) begin
      idx = deg - DEG_HALF;
      neg = 1'b1;
    end else begin
      idx = DEG_FULL - deg;
      neg = 1'b1;
    end
    return {neg, idx[IDX_W-1:0]};
  endfunction

  logic [ANG_W-1:0]        sin_deg;
  logic [ANG_W-1:0]        cos_sum;
  logic [ANG_W-1:0]        cos_deg;
  logic [IDX_W:0]          sin_fold;
  logic [IDX_W:0]          cos_fold;
  logic signed [SIN_W-1:0] sin_mag;
  logic signed [SIN_W-1:0] cos_mag;

  always_comb begin
    // A full turn reads as zero degrees.
    sin_deg  = (angle_i >= DEG_FULL) ? '0 : angle_i;
    cos_sum  = sin_deg + DEG_QUARTER;
    cos_deg  = (cos_sum >= DEG_FULL) ? (cos_sum - DEG_FULL) : cos_sum;
    sin_fold = fold(sin_deg);
    cos_fold = fold(cos_deg);
    sin_mag  = $signed({1'b0, sin_tab[sin_fold[IDX_W-1:0]]});
    cos_mag  = $signed({1'b0, sin_tab[cos_fold[IDX_W-1:0]]});
    sin_o    = sin_fold[IDX_W] ? -sin_mag : sin_mag;
    cos_o    = cos_fold[IDX_W] ? -cos_mag : cos_mag;
  end

endmodule

// File: rtl/ocyp_mac.sv
`timescale 1ns / 1ps
module ocyp_mac import ocyp_pkg::*; #(
  parameter int unsigned SINE_FRAC_BITS = SINE_FRAC_BITS_DFLT,
  parameter int unsigned OUT_FRAC_BITS  = OUT_FRAC_BITS_DFLT
) (
  input  logic                             clk_i,
  input  mac_op_t                          op_i,
  input  logic signed [SINE_FRAC_BITS+9:0] a_i,
  input  logic signed [SINE_FRAC_BITS+1:0] b_i,
  output logic signed [SINE_FRAC_BITS+9:0] sum_o,
  output logic signed [OUT_W-1:0]          rnd_o
);

  localparam int unsigned A_W   = SINE_FRAC_BITS + 10;
  localparam int unsigned B_W   = SINE_FRAC_BITS + 2;
  localparam int unsigned ACC_W = A_W + B_W;
  localparam int unsigned SH    = 2 * SINE_FRAC_BITS - OUT_FRAC_BITS;

  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(64'd1 << (SH - 1));
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(OUT_MIN);

  logic signed [ACC_W-1:0] prod_d;
  logic signed [ACC_W-1:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] mag;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] scaled;

  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= sum;
  end

  always_comb begin
    if (op_i.use_acc) begin
      base = acc_q;
    end else if (op_i.add_half) begin
      base = HALF;
    end else begin
      base = '0;
    end
    mag    = op_i.shift_up ? (prod_q <<< SINE_FRAC_BITS) : prod_q;
    sum    = op_i.negate ? (base - mag) : (base + mag);
    scaled = sum >>> SH;
    priority if (scaled > SAT_HI) begin
      rnd_o = OUT_W'(OUT_MAX);
    end else if (scaled < SAT_LO) begin
      rnd_o = OUT_W'(OUT_MIN);
    end else begin
      rnd_o = scaled[OUT_W-1:0];
    end
    sum_o = sum[A_W-1:0];
  end

endmodule

// File: rtl/orbit_camera_yaw_pitch_rotate_unit.sv
`timescale 1ns / 1ps
// An accepted input beat passes through the angle update, the sine lookup, a run in which
// the single shared multiplier forms the 16 products of the two rotations through the
// product register, and the output load, which waits while the output is not drained.
// A new input beat is taken only when idle, after the last result has been loaded.
// Reset clears the angles and the last pointer position and loads the register defaults.
`include "orbit_camera_yaw_pitch_rotate_unit_assert.svh"
module orbit_camera_yaw_pitch_rotate_unit import ocyp_pkg::*; #(
  parameter int unsigned SINE_FRAC_BITS = SINE_FRAC_BITS_DFLT,
  parameter int unsigned OUT_FRAC_BITS  = OUT_FRAC_BITS_DFLT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input stream: tdata = pointer_x[12:0], pointer_y[25:13], zero fill [31:26].
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser = func (0 press, 1 drag).
  input  logic [0:0]             s_axis_tuser_i,
  // Output stream: tdata = eye_out_x, eye_out_y, eye_out_z, up_out_x, up_out_y,
  // up_out_z, 15 bits each from bit 0 up, zero fill [95:90].
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // Register write channel.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [VEC_W-1:0]       cfg_data_i
);

  localparam int unsigned SIN_W = SINE_FRAC_BITS + 2;
  localparam int unsigned A_W   = SINE_FRAC_BITS + 10;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_TRIG = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // Products formed for one vector, in issue order. The accumulate stage works on
  // the product of the previous step, so the run lasts one step longer than the
  // sixteen products of both vectors.
  localparam logic [2:0] ST_ZSY = 3'd0;  // vz * sin(yaw)
  localparam logic [2:0] ST_XCY = 3'd1;  // vx * cos(yaw), completes rotated x
  localparam logic [2:0] ST_ZCY = 3'd2;  // vz * cos(yaw)
  localparam logic [2:0] ST_XSY = 3'd3;  // vx * sin(yaw), completes intermediate z
  localparam logic [2:0] ST_YCP = 3'd4;  // vy * cos(pitch)
  localparam logic [2:0] ST_ZSP = 3'd5;  // z * sin(pitch), completes rotated y
  localparam logic [2:0] ST_YSP = 3'd6;  // vy * sin(pitch)
  localparam logic [2:0] ST_ZCP = 3'd7;  // z * cos(pitch), completes rotated z

  localparam logic [4:0] LAST_STEP = 5'd16;

  logic [2:0] state_q, state_d;
  logic [4:0] step_q, step_d;

  // Configuration registers.
  logic                    yaw_lock_q;
  logic                    pitch_lock_q;
  logic signed [VEC_W-1:0] eye_q [3];
  logic signed [VEC_W-1:0] up_q [3];

  // Captured input beat.
  logic                    func_q;
  logic signed [PTR_W-1:0] px_q;
  logic signed [PTR_W-1:0] py_q;

  // Camera state.
  logic signed [PTR_W-1:0] last_px_q;
  logic signed [PTR_W-1:0] last_py_q;
  logic [ANG_W-1:0]        yaw_q, yaw_d;
  logic [ANG_W-1:0]        pitch_q, pitch_d;

  // Sines and cosines of the current angles, held for the whole run.
  logic signed [SIN_W-1:0] sin_yaw, cos_yaw, sin_pitch, cos_pitch;
  logic signed [SIN_W-1:0] sy_q, cy_q, sp_q, cp_q;

  logic signed [A_W-1:0]   z_q;
  logic signed [OUT_W-1:0] res_q [2][3];
  logic [OUT_TDATA_W-1:0]  out_data_q;
  logic                    out_valid_q;

  logic in_accept;
  logic out_load;

  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign out_load        = (state_q == S_DONE) && (!out_valid_q || m_axis_tready_i);

  // Angle update. The sum can leave 0..360 by any amount; it wraps to a fixed angle.
  function automatic logic [ANG_W-1:0] wrap_angle(input logic signed [PTR_W+1:0] a);
    priority if (a > $signed((PTR_W + 2)'(DEG_FULL))) begin
      return DEG_ONE;
    end else if (a < 0) begin
      return DEG_WRAP_LOW;
    end else begin
      return a[ANG_W-1:0];
    end
  endfunction

  logic signed [PTR_W:0]   delta_x, delta_y;
  logic signed [PTR_W+1:0] yaw_sum, pitch_sum;

  always_comb begin
    delta_x   = $signed({px_q[PTR_W-1], px_q}) - $signed({last_px_q[PTR_W-1], last_px_q});
    delta_y   = $signed({py_q[PTR_W-1], py_q}) - $signed({last_py_q[PTR_W-1], last_py_q});
    yaw_sum   = $signed({{(PTR_W + 2 - ANG_W){1'b0}}, yaw_q}) + {delta_x[PTR_W], delta_x};
    pitch_sum = $signed({{(PTR_W + 2 - ANG_W){1'b0}}, pitch_q}) + {delta_y[PTR_W], delta_y};
    yaw_d     = (func_q && !yaw_lock_q) ? wrap_angle(yaw_sum) : yaw_q;
    pitch_d   = (func_q && !pitch_lock_q) ? wrap_angle(pitch_sum) : pitch_q;
  end

  ocyp_sincos #(
    .SINE_FRAC_BITS(SINE_FRAC_BITS)
  ) u_sincos_yaw (
    .angle_i(yaw_q),
    .sin_o  (sin_yaw),
    .cos_o  (cos_yaw)
  );

  ocyp_sincos #(
    .SINE_FRAC_BITS(SINE_FRAC_BITS)
  ) u_sincos_pitch (
    .angle_i(pitch_q),
    .sin_o  (sin_pitch),
    .cos_o  (cos_pitch)
  );

  // Multiply stage operands: step bit 3 picks the eye or the up vector.
  logic                    mul_vec;
  logic signed [VEC_W-1:0] vx, vy, vz;
  logic signed [A_W-1:0]   mul_a;
  logic signed [SIN_W-1:0] mul_b;

  always_comb begin
    mul_vec = step_q[3];
    vx      = mul_vec ? up_q[0] : eye_q[0];
    vy      = mul_vec ? up_q[1] : eye_q[1];
    vz      = mul_vec ? up_q[2] : eye_q[2];
    unique case (step_q[2:0])
      ST_ZSY: begin mul_a = A_W'(vz); mul_b = sy_q; end
      ST_XCY: begin mul_a = A_W'(vx); mul_b = cy_q; end
      ST_ZCY: begin mul_a = A_W'(vz); mul_b = cy_q; end
      ST_XSY: begin mul_a = A_W'(vx); mul_b = sy_q; end
      ST_YCP: begin mul_a = A_W'(vy); mul_b = cp_q; end
      ST_ZSP: begin mul_a = z_q;      mul_b = sp_q; end
      ST_YSP: begin mul_a = A_W'(vy); mul_b = sp_q; end
      ST_ZCP: begin mul_a = z_q;      mul_b = cp_q; end
      default: begin mul_a = '0;      mul_b = '0;   end
    endcase
  end

  // Accumulate stage: works on the product issued in the previous step. Outputs are
  // formed at twice the sine precision with the rounding offset preloaded.
  logic [4:0]              add_step;
  logic                    add_vec;
  logic                    add_en;
  mac_op_t                 mac_op;
  logic signed [A_W-1:0]   mac_sum;
  logic signed [OUT_W-1:0] mac_rnd;

  always_comb begin
    add_step = step_q - 5'd1;
    add_vec  = add_step[3];
    add_en   = (state_q == S_RUN) && (step_q != '0);
    unique case (add_step[2:0])
      ST_ZSY: mac_op = '{use_acc: 1'b0, add_half: 1'b1, shift_up: 1'b1, negate: 1'b0};
      ST_XCY: mac_op = '{use_acc: 1'b1, add_half: 1'b0, shift_up: 1'b1, negate: 1'b0};
      ST_ZCY: mac_op = '{use_acc: 1'b0, add_half: 1'b0, shift_up: 1'b0, negate: 1'b0};
      ST_XSY: mac_op = '{use_acc: 1'b1, add_half: 1'b0, shift_up: 1'b0, negate: 1'b1};
      ST_YCP: mac_op = '{use_acc: 1'b0, add_half: 1'b1, shift_up: 1'b1, negate: 1'b0};
      ST_ZSP: mac_op = '{use_acc: 1'b1, add_half: 1'b0, shift_up: 1'b0, negate: 1'b1};
      ST_YSP: mac_op = '{use_acc: 1'b0, add_half: 1'b1, shift_up: 1'b1, negate: 1'b0};
      ST_ZCP: mac_op = '{use_acc: 1'b1, add_half: 1'b0, shift_up: 1'b0, negate: 1'b0};
      default: mac_op = '0;
    endcase
  end

  ocyp_mac #(
    .SINE_FRAC_BITS(SINE_FRAC_BITS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_mac (
    .clk_i(clk_i),
    .op_i (mac_op),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .sum_o(mac_sum),
    .rnd_o(mac_rnd)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        state_d = S_TRIG;
      end
      S_TRIG: begin
        step_d  = '0;
        state_d = S_RUN;
      end
      S_RUN: begin
        step_d = step_q + 5'd1;
        if (step_q == LAST_STEP) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      last_px_q   <= '0;
      last_py_q   <= '0;
      yaw_q       <= '0;
      pitch_q     <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      // A press and a drag both record the new pointer position.
      if (state_q == S_UPD) begin
        last_px_q <= px_q;
        last_py_q <= py_q;
        yaw_q     <= yaw_d;
        pitch_q   <= pitch_d;
      end
    end
  end

  // Register file. Writes must arrive only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_lock_q   <= 1'b0;
      pitch_lock_q <= 1'b0;
      eye_q[0]     <= 8'sd0;
      eye_q[1]     <= 8'sd30;
      eye_q[2]     <= 8'sd40;
      up_q[0]      <= 8'sd0;
      up_q[1]      <= 8'sd10;
      up_q[2]      <= 8'sd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        CFG_YAW_LOCK:   yaw_lock_q   <= cfg_data_i[0];
        CFG_PITCH_LOCK: pitch_lock_q <= cfg_data_i[0];
        CFG_EYE_X:      eye_q[0]     <= cfg_data_i;
        CFG_EYE_Y:      eye_q[1]     <= cfg_data_i;
        CFG_EYE_Z:      eye_q[2]     <= cfg_data_i;
        CFG_UP_X:       up_q[0]      <= cfg_data_i;
        CFG_UP_Y:       up_q[1]      <= cfg_data_i;
        CFG_UP_Z:       up_q[2]      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q <= s_axis_tuser_i[0];
      px_q   <= s_axis_tdata_i[PTR_W-1:0];
      py_q   <= s_axis_tdata_i[2*PTR_W-1:PTR_W];
    end
    if (state_q == S_TRIG) begin
      sy_q <= sin_yaw;
      cy_q <= cos_yaw;
      sp_q <= sin_pitch;
      cp_q <= cos_pitch;
    end
    if (add_en) begin
      unique case (add_step[2:0])
        ST_XCY: res_q[add_vec][0] <= mac_rnd;
        ST_XSY: z_q               <= mac_sum;
        ST_ZSP: res_q[add_vec][1] <= mac_rnd;
        ST_ZCP: res_q[add_vec][2] <= mac_rnd;
        default: begin
        end
      endcase
    end
    if (out_load) begin
      out_data_q <= {{(OUT_TDATA_W - 6 * OUT_W){1'b0}},
                     res_q[1][2], res_q[1][1], res_q[1][0],
                     res_q[0][2], res_q[0][1], res_q[0][0]};
    end
  end

  `OCYP_ASSERT(a_angle_range, clk_i, rst_ni, (yaw_q <= DEG_FULL) && (pitch_q <= DEG_FULL), "angle left the range 0 to 360")
  `OCYP_ASSERT(a_step_bound, clk_i, rst_ni, (state_q != S_RUN) || (step_q <= LAST_STEP), "step counter overran the run")
  `OCYP_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_accept, state_q == S_UPD, "accepted beat did not start an update")
  `OCYP_ASSERT_NEXT(a_result_offered, clk_i, rst_ni, out_load, m_axis_tvalid_o && (state_q == S_IDLE), "finished result was not offered")

endmodule

// File: tb/tb_orbit_camera_yaw_pitch_rotate_unit.sv
`timescale 1ns / 1ps
module tb_orbit_camera_yaw_pitch_rotate_unit;
  import ocyp_pkg::*;

  // Fixed-point formats of the unit under test (its parameter defaults).
  localparam int SINE_BITS   = SINE_FRAC_BITS_DFLT;
  localparam int OUT_BITS    = OUT_FRAC_BITS_DFLT;
  // The second rotation leaves values in Q(2*SINE_BITS); this many bits are rounded off.
  localparam int ROUND_SHIFT = 2 * SINE_BITS - OUT_BITS;

  localparam int PTR_MAX = (1 << (PTR_W - 1)) - 1;
  localparam int PTR_MIN = -(1 << (PTR_W - 1));

  localparam int QTR_DEG  = int'(DEG_QUARTER);
  localparam int HALF_DEG = int'(DEG_HALF);
  localparam int TQTR_DEG = int'(DEG_3QUARTER);
  localparam int FULL_DEG = int'(DEG_FULL);

  // Roughly 1250 events, with their stalls, stay far below this.
  localparam int CYCLE_LIMIT   = 600000;
  localparam int REPORT_MAX    = 10;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_EVENTS  = 123;

  typedef enum logic {
    PTR_PRESS = 1'b0,
    PTR_DRAG  = 1'b1
  } ptr_func_e;

  typedef struct packed {
    ptr_func_e        func;
    logic [PTR_W-1:0] py;
    logic [PTR_W-1:0] px;
  } ptr_beat_t;

  // Clock, reset and every input of the unit start at known values.
  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  // tdata = pointer_x [12:0], pointer_y [25:13], zero fill [31:26].
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  // tuser = func (0 press, 1 drag).
  logic [0:0]             s_axis_tuser_i  = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  // tdata = eye_out_x, eye_out_y, eye_out_z, up_out_x, up_out_y, up_out_z from bit 0 up,
  // 15 bits each, zero fill [95:90].
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   cfg_valid_i     = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i      = CFG_YAW_LOCK;
  logic [VEC_W-1:0]       cfg_data_i      = '0;

  orbit_camera_yaw_pitch_rotate_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Camera predictor: its own copy of the registers, the angles and the last
  // recorded pointer position, plus the quarter-wave sine table in Q1.14.
  // ---------------------------------------------------------------------------
  int                      sine_q [0:90];
  logic                    yaw_locked   = 1'b0;
  logic                    pitch_locked = 1'b0;
  logic signed [VEC_W-1:0] eye_vec [3];
  logic signed [VEC_W-1:0] up_vec  [3];
  int                      cam_yaw, cam_pitch;
  int                      anchor_x, anchor_y;

  // Camera poses still owed by the unit, oldest first, and events not yet offered.
  logic [OUT_TDATA_W-1:0]  pose_q [$];
  ptr_beat_t               pending_q [$];

  string pose_field [6] = '{"eye_out_x", "eye_out_y", "eye_out_z",
                            "up_out_x", "up_out_y", "up_out_z"};

  int beats_offered = 0;
  int beats_taken   = 0;
  int press_cnt     = 0;
  int drag_cnt      = 0;
  int results_seen  = 0;
  int cfg_writes    = 0;
  int settings_cnt  = 0;
  int fail_cnt      = 0;
  int idle_pct      = 35;
  logic want_hold   = 1'b0;
  logic hold_used   = 1'b0;
  int hold_left     = 0;
  int watch_cycles  = 0;

  ptr_beat_t              next_beat;
  ptr_beat_t              taken_beat;
  logic [OUT_TDATA_W-1:0] fresh_pose;

  // Sine of a whole degree in 0..90: Taylor series in Q30, rounded to SINE_BITS.
  function automatic int quarter_sine(int deg);
    longint unsigned ang, ang_sq, term, acc;
    ang    = (64'(deg) * PI_Q30) / 64'd180;
    ang_sq = (ang * ang) >> 30;
    term   = ang;
    acc    = ang;
    for (int k = 1; k <= 10; k++) begin
      term = ((term * ang_sq) >> 30) / 64'(4 * k * k + 2 * k);
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return int'((acc + (64'd1 << (29 - SINE_BITS))) >> (30 - SINE_BITS));
  endfunction

  // Full-circle sine from the quarter table by symmetry.
  function automatic longint sine_of(int deg);
    int d;
    d = deg % FULL_DEG;
    if (d < 0) d += FULL_DEG;
    if (d <= QTR_DEG) return sine_q[d];
    if (d <= HALF_DEG) return sine_q[HALF_DEG - d];
    if (d <= TQTR_DEG) return -sine_q[d - HALF_DEG];
    return -sine_q[FULL_DEG - d];
  endfunction

  // Round to Q9.6 with ties toward plus infinity, then saturate.
  function automatic logic [OUT_W-1:0] to_q9_6(longint v);
    longint r;
    r = (v + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    if (r > OUT_MAX) r = OUT_MAX;
    if (r < OUT_MIN) r = OUT_MIN;
    return r[OUT_W-1:0];
  endfunction

  // Rotate about y by the yaw angle, then about x by the pitch angle.
  // Returns {z, y, x} so that x lands in the low bits.
  function automatic logic [3*OUT_W-1:0] rotate_vector(logic signed [VEC_W-1:0] ax,
                                                       logic signed [VEC_W-1:0] ay,
                                                       logic signed [VEC_W-1:0] az);
    longint vx, vy, vz, sy, cy, sp, cp, one, rx, ry, rz;
    vx  = ax;
    vy  = ay;
    vz  = az;
    sy  = sine_of(cam_yaw);
    cy  = sine_of(cam_yaw + QTR_DEG);
    sp  = sine_of(cam_pitch);
    cp  = sine_of(cam_pitch + QTR_DEG);
    one = longint'(1) <<< SINE_BITS;
    rx  = vz * sy + vx * cy;
    ry  = vy * one;
    rz  = vz * cy - vx * sy;
    return {to_q9_6(ry * sp + rz * cp), to_q9_6(ry * cp - rz * sp), to_q9_6(rx * one)};
  endfunction

  // An angle past a full turn restarts at one degree, a negative one at 359.
  function automatic int wrap_deg(int a);
    if (a > FULL_DEG) return int'(DEG_ONE);
    if (a < 0) return int'(DEG_WRAP_LOW);
    return a;
  endfunction

  // Advance the camera by one pointer event and return the pose it reports.
  task automatic predict_pose(input ptr_beat_t b, output logic [OUT_TDATA_W-1:0] pose);
    int px, py;
    px = $signed(b.px);
    py = $signed(b.py);
    if (b.func == PTR_DRAG) begin
      if (!yaw_locked) cam_yaw += px - anchor_x;
      if (!pitch_locked) cam_pitch += py - anchor_y;
      cam_yaw   = wrap_deg(cam_yaw);
      cam_pitch = wrap_deg(cam_pitch);
    end
    anchor_x = px;
    anchor_y = py;
    pose = {6'b0, rotate_vector(up_vec[0], up_vec[1], up_vec[2]),
            rotate_vector(eye_vec[0], eye_vec[1], eye_vec[2])};
  endtask

  task automatic note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= REPORT_MAX) $display("MISMATCH: %s", msg);
  endtask

  // Compare one result beat, field by field, with the oldest owed pose.
  task automatic check_pose(input logic [OUT_TDATA_W-1:0] got);
    logic [OUT_TDATA_W-1:0] want;
    if (pose_q.size() == 0) begin
      note_failure($sformatf("result beat %h arrived with no event pending", got));
      return;
    end
    want = pose_q.pop_front();
    results_seen++;
    for (int f = 0; f < 6; f++) begin
      if (got[f*OUT_W +: OUT_W] !== want[f*OUT_W +: OUT_W]) begin
        note_failure($sformatf("result %0d %s: expected %0d, got %0d", results_seen,
                               pose_field[f], $signed(want[f*OUT_W +: OUT_W]),
                               $signed(got[f*OUT_W +: OUT_W])));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: both streams are sampled at the rising edge. The result check runs
  // before the prediction so that a result never meets its own event's pose.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) check_pose(m_axis_tdata_o);
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        taken_beat.func = ptr_func_e'(s_axis_tuser_i[0]);
        taken_beat.px   = s_axis_tdata_i[PTR_W-1:0];
        taken_beat.py   = s_axis_tdata_i[2*PTR_W-1:PTR_W];
        predict_pose(taken_beat, fresh_pose);
        pose_q.push_back(fresh_pose);
        beats_taken++;
        if (taken_beat.func == PTR_DRAG) drag_cnt++;
        else press_cnt++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pointer event driver: a beat stays on the bus until the monitor has counted
  // it as taken; only then may the next one, or an idle cycle, follow.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && beats_offered == beats_taken) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_beat = pending_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {{(IN_TDATA_W - 2 * PTR_W){1'b0}}, next_beat.py, next_beat.px};
        s_axis_tuser_i  <= next_beat.func;
        beats_offered++;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Result receiver: random back-pressure, and once a long hold-off while the
  // driver keeps offering events, so the unit fills and stalls its input.
  always @(negedge clk_i) begin
    if (want_hold && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= rst_ni && ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog: a hang ends the run as a failure.
  initial begin
    while (watch_cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      watch_cycles++;
    end
    $display("Timeout after %0d cycles, %0d results still owed", CYCLE_LIMIT, pose_q.size());
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_beat(input ptr_func_e f, input int x, input int y);
    ptr_beat_t b;
    b.func = f;
    b.px   = x[PTR_W-1:0];
    b.py   = y[PTR_W-1:0];
    pending_q.push_back(b);
  endtask

  // One register write; the predictor copy follows at the handshake.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [VEC_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_YAW_LOCK:   yaw_locked   = val[0];
      CFG_PITCH_LOCK: pitch_locked = val[0];
      CFG_EYE_X:      eye_vec[0]   = val;
      CFG_EYE_Y:      eye_vec[1]   = val;
      CFG_EYE_Z:      eye_vec[2]   = val;
      CFG_UP_X:       up_vec[0]    = val;
      CFG_UP_Y:       up_vec[1]    = val;
      default:        up_vec[2]    = val;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_camera(input logic [VEC_W-1:0] ylock, input logic [VEC_W-1:0] plock,
                             input logic [VEC_W-1:0] ex, input logic [VEC_W-1:0] ey,
                             input logic [VEC_W-1:0] ez, input logic [VEC_W-1:0] ux,
                             input logic [VEC_W-1:0] uy, input logic [VEC_W-1:0] uz);
    write_reg(CFG_YAW_LOCK, ylock);
    write_reg(CFG_PITCH_LOCK, plock);
    write_reg(CFG_EYE_X, ex);
    write_reg(CFG_EYE_Y, ey);
    write_reg(CFG_EYE_Z, ez);
    write_reg(CFG_UP_X, ux);
    write_reg(CFG_UP_Y, uy);
    write_reg(CFG_UP_Z, uz);
    settings_cnt++;
  endtask

  // Registers change only once every event has been taken and every pose has
  // come back, followed by a short pause for the unit to settle.
  task automatic wait_idle();
    while (pending_q.size() != 0 || beats_offered != beats_taken || pose_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly a press followed by a run of drags with small random moves, now and
  // then a long jump across the wrap point; the rest is a drag with no press
  // or a lone event anywhere in the full pointer range.
  task automatic queue_gesture(output int cnt);
    int kind, x, y, n, step;
    kind = $urandom_range(99);
    cnt  = 0;
    if (kind < 15) begin
      push_beat(ptr_func_e'($urandom_range(1)), $urandom, $urandom);
      cnt = 1;
    end else begin
      if ($urandom_range(3) == 0) begin
        x = int'($urandom_range(8191)) + PTR_MIN;
        y = int'($urandom_range(8191)) + PTR_MIN;
      end else begin
        x = int'($urandom_range(800)) - 400;
        y = int'($urandom_range(800)) - 400;
      end
      if (kind < 85) begin
        push_beat(PTR_PRESS, x, y);
        cnt++;
      end
      n = $urandom_range(8, 1);
      repeat (n) begin
        step = ($urandom_range(9) == 0) ? 1000 : 60;
        x = x + int'($urandom_range(2 * step)) - step;
        y = y + int'($urandom_range(2 * step)) - step;
        if (x > PTR_MAX) x = PTR_MAX;
        if (x < PTR_MIN) x = PTR_MIN;
        if (y > PTR_MAX) y = PTR_MAX;
        if (y < PTR_MIN) y = PTR_MIN;
        push_beat(PTR_DRAG, x, y);
        cnt++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int got, budget;
    logic [VEC_W-1:0] yl, pl;

    // Predictor state after reset: zero angles and anchor, default vectors.
    for (int d = 0; d <= QTR_DEG; d++) sine_q[d] = quarter_sine(d);
    eye_vec   = '{8'sd0, 8'sd30, 8'sd40};
    up_vec    = '{8'sd0, 8'sd10, 8'sd0};
    cam_yaw   = 0;
    cam_pitch = 0;
    anchor_x  = 0;
    anchor_y  = 0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed events under the reset settings. The first drag has no press
    // before it and pulls pitch below zero; the full-range drag wraps both
    // axes; then yaw lands exactly on 360 (kept) and one past it, pitch goes
    // to zero and below, and the angles step through the quadrant edges.
    push_beat(PTR_DRAG, 30, -20);
    push_beat(PTR_PRESS, PTR_MAX, PTR_MIN);
    push_beat(PTR_DRAG, PTR_MIN, PTR_MAX);
    push_beat(PTR_PRESS, 0, 0);
    push_beat(PTR_DRAG, 1, -1);
    push_beat(PTR_DRAG, 2, -2);
    push_beat(PTR_DRAG, 91, -92);
    push_beat(PTR_DRAG, 181, -2);
    push_beat(PTR_DRAG, 271, 88);
    push_beat(PTR_PRESS, -1, -1);
    push_beat(PTR_DRAG, -1, -1);
    push_beat(PTR_PRESS, 2730, -2731);
    wait_idle();

    // Extreme vectors with both axes free.
    load_camera(8'd0, 8'd0, 8'h80, 8'h80, 8'h80, 8'h7F, 8'h7F, 8'h7F);
    push_beat(PTR_PRESS, 0, 0);
    push_beat(PTR_DRAG, 45, 45);
    push_beat(PTR_DRAG, 90, 90);
    push_beat(PTR_DRAG, 225, -135);
    wait_idle();

    // Yaw frozen: horizontal moves must leave the yaw angle alone.
    write_reg(CFG_YAW_LOCK, 8'd1);
    push_beat(PTR_DRAG, 400, 100);
    push_beat(PTR_DRAG, -400, 5);
    wait_idle();

    // Pitch frozen instead, then both axes frozen.
    write_reg(CFG_YAW_LOCK, 8'd0);
    write_reg(CFG_PITCH_LOCK, 8'd1);
    push_beat(PTR_DRAG, -300, 700);
    push_beat(PTR_DRAG, 17, -900);
    wait_idle();
    write_reg(CFG_YAW_LOCK, 8'd1);
    push_beat(PTR_DRAG, 500, 500);
    push_beat(PTR_PRESS, -4000, 4000);
    push_beat(PTR_DRAG, 4000, -4000);
    wait_idle();

    // Random phases, each under a fresh camera setting. Phases 0..2 use the
    // extreme and zero vectors; phase 3 carries the long output hold-off and
    // phase 6 runs with no idling on either side.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      yl = {7'($urandom), ($urandom_range(4) == 0)};
      pl = {7'($urandom), ($urandom_range(4) == 0)};
      if (ph == 4) yl = 8'd1;
      if (ph == 5) pl = 8'd1;
      case (ph)
        0:       load_camera(yl, pl, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F);
        1:       load_camera(yl, pl, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80);
        2:       load_camera(yl, pl, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        default: load_camera(yl, pl, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      idle_pct = (ph == 6) ? 0 : 35;
      if (ph == 3) want_hold = 1'b1;
      budget = 0;
      while (budget < PHASE_EVENTS) begin
        queue_gesture(got);
        budget += got;
      end
    end

    wait_idle();
    repeat (30) @(posedge clk_i);
    if (pose_q.size() != 0) note_failure($sformatf("%0d results never arrived", pose_q.size()));

    $display("Covered %0d pointer events (%0d presses, %0d drags) under %0d camera settings",
             beats_taken, press_cnt, drag_cnt, settings_cnt + 1);
    $display("with %0d register writes, axis locks, angle wraps and a long output stall; %0d results checked, %0d failures",
             cfg_writes, results_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
